[rtl/rdc_pkg.sv]
// repeating decimal cycle: shared types, widths and constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rdc_pkg;

   localparam int MAX_DEN   = 64;
   localparam int NUM_W     = 16;
   localparam int DEN_W     = 7;
   localparam int DIGIT_W   = 4;
   localparam int LEN_W     = 6;
   localparam int STEP_W    = 7;
   localparam int REM_W     = $clog2(MAX_DEN);
   localparam int VAL_W     = REM_W + 4;
   localparam int NIB_NUM   = NUM_W / 4;
   localparam int NIB_W     = $clog2(NIB_NUM);
   localparam int RADIX_DEC = 10;

   typedef logic [REM_W-1:0]   rem_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [DEN_W-1:0]   den_type;
   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [VAL_W-1:0]   val_type;

   typedef struct packed {
      logic clear;
      logic write;
   } tbl_ctrl_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MOD  = 5'b00010,
      ST_FIND = 5'b00100,
      ST_LEN  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

endpackage

[rtl/rdc_step_unit.sv]
// shared divide step: (rem * 16 + nibble) or (rem * 10) divided by the denominator
// four compare-subtract stages giving a 4-bit quotient and the new remainder; uses rdc_pkg
`timescale 1ns / 1ps

module rdc_step_unit (
   input  rdc_pkg::rem_type   rem_in,
   input  logic               use_hex,
   input  logic [3:0]         chunk,
   input  rdc_pkg::den_type   den,
   output rdc_pkg::digit_type quot,
   output rdc_pkg::rem_type   rem_out
);
   import rdc_pkg::*;

   val_type   val;
   val_type   dsh;
   digit_type q;

   always_comb begin
      if (use_hex) begin
         val = VAL_W'({rem_in, chunk});
      end else begin
         val = VAL_W'({rem_in, 3'b000}) + VAL_W'({rem_in, 1'b0});
      end
      q = '0;
      for (int i = 3; i >= 0; i--) begin
         dsh = VAL_W'(den) << i;
         if (val >= dsh) begin
            val  = val - dsh;
            q[i] = 1'b1;
         end
      end
      quot    = q;
      rem_out = val[REM_W-1:0];
   end

endmodule

[rtl/rdc_seen_table.sv]
// position table: step at which each remainder was first seen, with per-entry valid bits
// step memory has a registered read; uses rdc_pkg
`timescale 1ns / 1ps

module rdc_seen_table (
   input  logic                  clock,
   input  logic                  reset,
   input  rdc_pkg::tbl_ctrl_type ctrl,
   input  rdc_pkg::rem_type      addr,
   input  rdc_pkg::step_type     wr_step,
   output logic                  hit,
   output rdc_pkg::step_type     rd_step
);
   import rdc_pkg::*;

   logic [MAX_DEN-1:0] valid_ff;
   step_type           mem [MAX_DEN];
   step_type           rd_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.clear) begin
         valid_ff <= '0;
      end else if (ctrl.write) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         mem[addr] <= wr_step;
      end
      rd_step_ff <= mem[addr];
   end

   assign hit     = valid_ff[addr];
   assign rd_step = rd_step_ff;

endmodule

[rtl/repeating_decimal_cycle.sv]
// repeating decimal cycle: sequencer around the shared divide step and the position table
// depends on rdc_pkg, rdc_step_unit and rdc_seen_table
`timescale 1ns / 1ps

// Usage:
//   Pulse start with req_numerator and req_denominator while busy is low; the
//   transfer happens on that edge and busy rises on the next cycle.
//   The denominator is clamped to 1..64 (zero counts as one).
//   Work per fraction: the numerator is first reduced one hex nibble per cycle,
//   then one long division step per cycle follows until a remainder
//   repeats or reaches zero, the position table is read, and then one
//   result per cycle is given for the repeating digits. Every step uses the same
//   four-stage compare-subtract unit; a new fraction is taken only after busy falls.
//   Results leave on the rsp_ ports from an output register, one per cycle,
//   each marked by a one-cycle rsp_strobe; the receiver cannot stall them.
//   A terminating fraction gives one result with rsp_terminates and rsp_last.
//   Synchronous reset returns the sequencer to idle and marks all table
//   entries unseen; the table is cleared again on each start transfer.
module repeating_decimal_cycle (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [rdc_pkg::NUM_W-1:0]  req_numerator,
   input  rdc_pkg::den_type           req_denominator,
   output logic                       rsp_strobe,
   output rdc_pkg::digit_type         rsp_digit,
   output rdc_pkg::len_type           rsp_cycle_length,
   output logic                       rsp_terminates,
   output logic                       rsp_last
);
   import rdc_pkg::*;

   state_type         state_ff, state_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   den_type           den_ff, den_in;
   rem_type           rem_ff, rem_in;
   logic [NIB_W-1:0]  nib_ff, nib_in;
   step_type          step_ff, step_in;
   len_type           len_ff, len_in;
   len_type           emit_ff, emit_in;

   logic              strobe_ff, strobe_in;
   digit_type         digit_ff, digit_in;
   len_type           cyc_len_ff, cyc_len_in;
   logic              term_ff, term_in;
   logic              last_ff, last_in;

   logic              use_hex;
   logic [3:0]        chunk;
   digit_type         unit_quot;
   rem_type           unit_rem;
   tbl_ctrl_type      tbl_ctrl;
   logic              tbl_hit;
   step_type          tbl_step;
   step_type          len_diff;
   den_type           den_sat;

   assign use_hex = (state_ff == ST_MOD);
   assign chunk   = use_hex ? num_ff[{nib_ff, 2'b00} +: 4] : 4'd0;

   rdc_step_unit u_step (
      .rem_in  (rem_ff),
      .use_hex (use_hex),
      .chunk   (chunk),
      .den     (den_ff),
      .quot    (unit_quot),
      .rem_out (unit_rem)
   );

   rdc_seen_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (tbl_ctrl),
      .addr    (rem_ff),
      .wr_step (step_ff),
      .hit     (tbl_hit),
      .rd_step (tbl_step)
   );

   assign len_diff = step_ff - tbl_step;

   always_comb begin
      if (req_denominator == '0) begin
         den_sat = DEN_W'(1);
      end else if (req_denominator > DEN_W'(MAX_DEN)) begin
         den_sat = DEN_W'(MAX_DEN);
      end else begin
         den_sat = req_denominator;
      end
   end

   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      nib_in     = nib_ff;
      step_in    = step_ff;
      len_in     = len_ff;
      emit_in    = emit_ff;
      strobe_in  = 1'b0;
      digit_in   = digit_ff;
      cyc_len_in = cyc_len_ff;
      term_in    = term_ff;
      last_in    = last_ff;
      tbl_ctrl   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in         = req_numerator;
               den_in         = den_sat;
               rem_in         = '0;
               nib_in         = NIB_W'(NIB_NUM - 1);
               tbl_ctrl.clear = 1'b1;
               state_in       = ST_MOD;
            end
         end
         ST_MOD: begin
            rem_in = unit_rem;
            nib_in = nib_ff - 1'b1;
            if (nib_ff == '0) begin
               step_in  = '0;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            priority if (rem_ff == '0) begin
               strobe_in  = 1'b1;
               digit_in   = '0;
               cyc_len_in = '0;
               term_in    = 1'b1;
               last_in    = 1'b1;
               state_in   = ST_IDLE;
            end else if (tbl_hit) begin
               state_in = ST_LEN;
            end else begin
               tbl_ctrl.write = 1'b1;
               rem_in         = unit_rem;
               step_in        = step_ff + 1'b1;
            end
         end
         ST_LEN: begin
            if (len_diff == '0) begin
               strobe_in  = 1'b1;
               digit_in   = '0;
               cyc_len_in = '0;
               term_in    = 1'b1;
               last_in    = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               len_in   = len_diff[LEN_W-1:0];
               emit_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            strobe_in  = 1'b1;
            digit_in   = unit_quot;
            cyc_len_in = len_ff;
            term_in    = 1'b0;
            last_in    = (emit_ff == len_ff - 1'b1);
            rem_in     = unit_rem;
            emit_in    = emit_ff + 1'b1;
            if (emit_ff == len_ff - 1'b1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         rem_ff    <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         rem_ff    <= rem_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      den_ff     <= den_in;
      nib_ff     <= nib_in;
      len_ff     <= len_in;
      emit_ff    <= emit_in;
      digit_ff   <= digit_in;
      cyc_len_ff <= cyc_len_in;
      term_ff    <= term_in;
      last_ff    <= last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_digit        = digit_ff;
   assign rsp_cycle_length = cyc_len_ff;
   assign rsp_terminates   = term_ff;
   assign rsp_last         = last_ff;

`ifndef ASSERT_OFF
   a_term_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_terminates |-> rsp_last && rsp_cycle_length == '0 && rsp_digit == '0)
      else $error("terminating result malformed");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_digit <= DIGIT_W'(RADIX_DEC - 1))
      else $error("digit out of range");

   a_cycle_len: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_terminates |-> rsp_cycle_length != '0)
      else $error("repeating result with zero cycle length");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND |-> step_ff <= STEP_W'(MAX_DEN))
      else $error("long division ran past table depth");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy || $past(start))
      else $error("last result while still busy");
`endif

endmodule

[bench/tb_repeating_decimal_cycle.sv]
// testbench for repeating_decimal_cycle: sends fractions, predicts the repeating digits
// and checks every result strobe against them; depends on rdc_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_repeating_decimal_cycle;
   import rdc_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 385;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      digit_type digit;
      len_type   cycle_length;
      logic      terminates;
      logic      last;
   } digit_result_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic [NUM_W-1:0]   req_numerator   = '0;
   den_type            req_denominator = '0;
   logic               busy;
   logic               rsp_strobe;
   digit_type          rsp_digit;
   len_type            rsp_cycle_length;
   logic               rsp_terminates;
   logic               rsp_last;

   digit_result_type   expected_digits[$];
   digit_result_type   oldest_digit;
   int                 mismatches  = 0;
   int                 idle_cycles = 0;

   repeating_decimal_cycle uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_numerator    (req_numerator),
      .req_denominator  (req_denominator),
      .rsp_strobe       (rsp_strobe),
      .rsp_digit        (rsp_digit),
      .rsp_cycle_length (rsp_cycle_length),
      .rsp_terminates   (rsp_terminates),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // long division with a first-seen table, then replay of the cycle digits
   function automatic void predict_expansion(input logic [NUM_W-1:0] num, input den_type den_in);
      int               den;
      int               rem;
      int               steps;
      int               len;
      int               prod;
      bit               seen [MAX_DEN];
      int               first_step [MAX_DEN];
      digit_result_type res;
      den = int'(den_in);
      if (den == 0) den = 1;
      if (den > MAX_DEN) den = MAX_DEN;
      foreach (seen[i]) begin
         seen[i] = 1'b0;
         first_step[i] = 0;
      end
      rem = int'(num) % den;
      steps = 0;
      len = 0;
      while (rem != 0 && !seen[rem]) begin
         seen[rem] = 1'b1;
         first_step[rem] = steps;
         rem = (rem * 10) % den;
         steps = (steps + 1) & 127;
      end
      if (rem != 0) len = (steps - first_step[rem]) & 127;
      if (len == 0) begin
         res.digit = '0;
         res.cycle_length = '0;
         res.terminates = 1'b1;
         res.last = 1'b1;
         expected_digits.push_back(res);
      end else begin
         for (int k = 0; k < len; k++) begin
            prod = rem * 10;
            res.digit = digit_type'((prod / den) & 15);
            res.cycle_length = len_type'(len & 63);
            res.terminates = 1'b0;
            res.last = (k == len - 1);
            expected_digits.push_back(res);
            rem = prod % den;
         end
      end
   endfunction

   task automatic note_mismatch(input string field, input int expected_v, input int actual_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %s: expected %0d, got %0d at %0t", field, expected_v, actual_v, $time);
   endtask

   // one fraction per transfer; start stays high so back-to-back items need no gap
   task automatic send_fraction(input logic [NUM_W-1:0] num, input den_type den);
      req_numerator <= num;
      req_denominator <= den;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_expansion(num, den);
   endtask

   // sender gap with junk on the request fields
   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) begin
            req_numerator <= NUM_W'($urandom);
            req_denominator <= den_type'($urandom);
            @(posedge clock);
         end
      end
   endtask

   task automatic test_terminating_fractions;
      send_fraction(16'd0, 7'd1);
      send_fraction(16'd65535, 7'd1);
      sender_gap(3);
      send_fraction(16'd1, 7'd2);
      send_fraction(16'd65535, 7'd64);
      send_fraction(16'd3, 7'd8);
      sender_gap(1);
      send_fraction(16'd7, 7'd40);
      send_fraction(16'd0, 7'd64);
      send_fraction(16'd12345, 7'd50);
   endtask

   task automatic test_repeating_fractions;
      send_fraction(16'd1, 7'd3);
      send_fraction(16'd65535, 7'd7);
      sender_gap(7);
      send_fraction(16'd1, 7'd61);
      send_fraction(16'd60, 7'd61);
      send_fraction(16'd1, 7'd63);
      send_fraction(16'd1, 7'd59);
      sender_gap(2);
      send_fraction(16'd5, 7'd6);
      send_fraction(16'd1, 7'd49);
      send_fraction(16'd32769, 7'd22);
   endtask

   task automatic test_denominator_clamp;
      send_fraction(16'd43690, 7'd0);
      send_fraction(16'd1, 7'd65);
      send_fraction(16'd65535, 7'd127);
      sender_gap(4);
      send_fraction(16'd5, 7'd100);
      send_fraction(16'd21845, 7'd96);
   endtask

   task automatic test_random_fractions(input int count);
      int      sent;
      int      burst;
      int      pick;
      den_type den;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst && sent < count; b++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) den = '0;
            else if (pick == 1) den = den_type'($urandom_range(65, 127));
            else if (pick == 2) den = den_type'($urandom_range(55, 64));
            else den = den_type'($urandom_range(1, 64));
            send_fraction(NUM_W'($urandom_range(0, 65535)), den);
            sent++;
         end
         pick = $urandom_range(0, 9);
         if (pick < 3) sender_gap(0);
         else if (pick < 8) sender_gap($urandom_range(1, 20));
         else sender_gap($urandom_range(21, 150));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            if (expected_digits.size() == 0) begin
               note_mismatch("unexpected result, digit", -1, int'(rsp_digit));
            end else begin
               oldest_digit = expected_digits.pop_front();
               if (rsp_digit !== oldest_digit.digit)
                  note_mismatch("digit", int'(oldest_digit.digit), int'(rsp_digit));
               if (rsp_cycle_length !== oldest_digit.cycle_length)
                  note_mismatch("cycle_length", int'(oldest_digit.cycle_length),
                                int'(rsp_cycle_length));
               if (rsp_terminates !== oldest_digit.terminates)
                  note_mismatch("terminates", int'(oldest_digit.terminates),
                                int'(rsp_terminates));
               if (rsp_last !== oldest_digit.last)
                  note_mismatch("last", int'(oldest_digit.last), int'(rsp_last));
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_terminating_fractions();
      test_repeating_fractions();
      test_denominator_clamp();
      test_random_fractions(RANDOM_ITEMS);
      start <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_digits.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/rdc_pkg.sv
rtl/rdc_step_unit.sv
rtl/rdc_seen_table.sv
rtl/repeating_decimal_cycle.sv
bench/tb_repeating_decimal_cycle.sv
